// ===== src/arcs_pkg.sv =====
// Shared types and constants for the auto-ranging current sense core.
// Used by arcs_ctrl and auto_ranging_current_sense_core; depends on nothing.
`default_nettype none

package arcs_pkg;

  // Fixed field widths.
  localparam int unsigned GAIN_W     = 2;
  localparam int unsigned LIMIT_W    = 12;
  localparam int unsigned TICKS_W    = 16;
  localparam int unsigned SCALE_W    = 24;
  localparam int unsigned CURRENT_W  = 36;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 24;

  // Gain index limits: 0 is 25 V/V, 3 is 200 V/V.
  localparam logic [GAIN_W-1:0] GAIN_BOTTOM = 2'd0;
  localparam logic [GAIN_W-1:0] GAIN_TOP    = 2'd3;

  // Register reset values.
  localparam logic [LIMIT_W-1:0] HIGH_LIMIT_RST    = 12'd3900;
  localparam logic [LIMIT_W-1:0] LOW_LIMIT_RST     = 12'd200;
  localparam logic [TICKS_W-1:0] HOLDOFF_TICKS_RST = 16'd1000;
  localparam logic [SCALE_W-1:0] BASE_SCALE_RST    = 24'd65536;

  // Item kinds.
  localparam logic FUNC_SAMPLE = 1'b0;
  localparam logic FUNC_TICK   = 1'b1;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_HIGH_LIMIT    = 3'd0,
    REG_LOW_LIMIT     = 3'd1,
    REG_HOLDOFF_TICKS = 3'd2,
    REG_BASE_SCALE    = 3'd3
  } cfg_reg_t;

  // Per-word status from the range control to the result stage.
  typedef struct packed {
    logic              current_valid;
    logic [GAIN_W-1:0] gain_used;
    logic [GAIN_W-1:0] gain_now;
    logic              holding_off;
  } ctrl_stat_t;

endpackage

`default_nettype wire

// ===== src/arcs_ctrl.sv =====
// Gain range decision and holdoff timer for the current sense core.
// Depends on arcs_pkg for widths, codes and the status struct.
`default_nettype none

module arcs_ctrl #(
  parameter int unsigned SAMPLE_BITS  = 12,
  parameter int unsigned HOLDOFF_BITS = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          fire,
  input  wire logic                          func,
  input  wire logic [SAMPLE_BITS-1:0]        sample,
  input  wire logic [arcs_pkg::LIMIT_W-1:0]  high_limit,
  input  wire logic [arcs_pkg::LIMIT_W-1:0]  low_limit,
  input  wire logic [arcs_pkg::TICKS_W-1:0]  holdoff_ticks,
  output arcs_pkg::ctrl_stat_t               stat
);

  localparam int unsigned SCMP_W =
    (SAMPLE_BITS > arcs_pkg::LIMIT_W) ? SAMPLE_BITS : arcs_pkg::LIMIT_W;
  localparam int unsigned HCMP_W =
    (HOLDOFF_BITS > arcs_pkg::TICKS_W) ? HOLDOFF_BITS : arcs_pkg::TICKS_W;
  localparam logic [HOLDOFF_BITS-1:0] HOLDOFF_MAX = {HOLDOFF_BITS{1'b1}};

  logic [arcs_pkg::GAIN_W-1:0] gain_r, gain_nxt;
  logic                        hold_r, hold_nxt;
  logic [HOLDOFF_BITS-1:0]     count_r, count_nxt;

  logic [SCMP_W-1:0]       sample_ext;
  logic [SCMP_W-1:0]       high_ext;
  logic [SCMP_W-1:0]       low_ext;
  logic [HOLDOFF_BITS-1:0] count_inc;
  logic                    count_done;
  logic                    is_valid;

  assign sample_ext = SCMP_W'(sample);
  assign high_ext   = SCMP_W'(high_limit);
  assign low_ext    = SCMP_W'(low_limit);

  // Saturating tick count and end-of-holdoff compare.
  assign count_inc  = (count_r < HOLDOFF_MAX) ? (count_r + 1'b1) : count_r;
  assign count_done = HCMP_W'(count_inc) >= HCMP_W'(holdoff_ticks);

  // Next state for one word; the high limit test wins over the low one.
  always_comb begin
    gain_nxt  = gain_r;
    hold_nxt  = hold_r;
    count_nxt = count_r;
    is_valid  = 1'b0;
    if (fire) begin
      if (func == arcs_pkg::FUNC_TICK) begin
        if (hold_r) begin
          if (count_done) begin
            hold_nxt  = 1'b0;
            count_nxt = '0;
          end else begin
            count_nxt = count_inc;
          end
        end
      end else if (!hold_r) begin
        is_valid = 1'b1;
        if (gain_r != arcs_pkg::GAIN_BOTTOM && sample_ext >= high_ext) begin
          gain_nxt  = gain_r - 1'b1;
          hold_nxt  = 1'b1;
          count_nxt = '0;
        end else if (gain_r != arcs_pkg::GAIN_TOP && sample_ext <= low_ext) begin
          gain_nxt  = gain_r + 1'b1;
          hold_nxt  = 1'b1;
          count_nxt = '0;
        end
      end
    end
  end

  // State registers; reset leaves the top gain with the holdoff running.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r  <= arcs_pkg::GAIN_TOP;
      hold_r  <= 1'b1;
      count_r <= '0;
    end else begin
      gain_r  <= gain_nxt;
      hold_r  <= hold_nxt;
      count_r <= count_nxt;
    end
  end

  // Status of the word being processed.
  always_comb begin
    stat.current_valid = is_valid;
    stat.gain_used     = gain_r;
    stat.gain_now      = gain_nxt;
    stat.holding_off   = hold_nxt;
  end

endmodule

`default_nettype wire

// ===== src/auto_ranging_current_sense_core.sv =====
// Top level of the auto-ranging current sense core: ports, registers,
// input and result stages, and the current multiply. Uses arcs_pkg, arcs_ctrl.
//
//   Port group | Direction | Handshake         | Contents
//   in_*       | input     | in_valid/in_stall | func, sample
//   out_*      | output    | out_valid/out_stall | current and gain status
//   cfg_*      | input     | cfg_we            | register index and data
//
// A word passes through the input register, then the range decision and a
// multiply by the 24-bit scale into the result register. One word is
// accepted every cycle while out_stall stays low.
// out_stall holds both stages; in_stall follows it only when the input stage
// is full. Synchronous reset empties both stages and loads register defaults.
`default_nettype none

module auto_ranging_current_sense_core #(
  parameter int unsigned SAMPLE_BITS  = 12,
  parameter int unsigned HOLDOFF_BITS = 16
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  // Input channel
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic                              in_func,
  input  wire logic [SAMPLE_BITS-1:0]            in_sample,
  // Result channel
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic                                   out_current_valid,
  output logic [arcs_pkg::CURRENT_W-1:0]         out_current_q16,
  output logic [arcs_pkg::GAIN_W-1:0]            out_gain_used,
  output logic [arcs_pkg::GAIN_W-1:0]            out_gain_index_now,
  output logic                                   out_select_pin_a,
  output logic                                   out_select_pin_b,
  output logic                                   out_holding_off,
  // Configuration port
  input  wire logic                              cfg_we,
  input  wire logic [arcs_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [arcs_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  localparam int unsigned PROD_W = SAMPLE_BITS + arcs_pkg::SCALE_W;
  localparam int unsigned EXT_W  =
    (PROD_W > arcs_pkg::CURRENT_W) ? PROD_W : arcs_pkg::CURRENT_W;

  // Configuration registers.
  logic [arcs_pkg::LIMIT_W-1:0] high_limit_r;
  logic [arcs_pkg::LIMIT_W-1:0] low_limit_r;
  logic [arcs_pkg::TICKS_W-1:0] holdoff_ticks_r;
  logic [arcs_pkg::SCALE_W-1:0] base_scale_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      high_limit_r    <= arcs_pkg::HIGH_LIMIT_RST;
      low_limit_r     <= arcs_pkg::LOW_LIMIT_RST;
      holdoff_ticks_r <= arcs_pkg::HOLDOFF_TICKS_RST;
      base_scale_r    <= arcs_pkg::BASE_SCALE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        arcs_pkg::REG_HIGH_LIMIT:    high_limit_r    <= cfg_wdata[arcs_pkg::LIMIT_W-1:0];
        arcs_pkg::REG_LOW_LIMIT:     low_limit_r     <= cfg_wdata[arcs_pkg::LIMIT_W-1:0];
        arcs_pkg::REG_HOLDOFF_TICKS: holdoff_ticks_r <= cfg_wdata[arcs_pkg::TICKS_W-1:0];
        arcs_pkg::REG_BASE_SCALE:    base_scale_r    <= cfg_wdata[arcs_pkg::SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  // Stage handshake: the input stage moves on when the result register frees.
  logic s1_valid_r;
  logic s1_func_r;
  logic [SAMPLE_BITS-1:0] s1_sample_r;
  logic advance;
  logic fire;

  assign advance  = !out_valid || !out_stall;
  assign fire     = s1_valid_r && advance;
  assign in_stall = s1_valid_r && !advance;

  // Input register; it also fills while empty even if the result side waits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_func_r   <= in_func;
      s1_sample_r <= in_sample;
    end
  end

  // Range decision and holdoff timer.
  arcs_pkg::ctrl_stat_t stat;

  arcs_ctrl #(
    .SAMPLE_BITS  (SAMPLE_BITS),
    .HOLDOFF_BITS (HOLDOFF_BITS)
  ) u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .fire          (fire),
    .func          (s1_func_r),
    .sample        (s1_sample_r),
    .high_limit    (high_limit_r),
    .low_limit     (low_limit_r),
    .holdoff_ticks (holdoff_ticks_r),
    .stat          (stat)
  );

  // Current: sample times scale, halved once per gain step, kept to 36 bits.
  logic [PROD_W-1:0]              product;
  logic [EXT_W-1:0]               shifted;
  logic [arcs_pkg::CURRENT_W-1:0] current;

  assign product = PROD_W'(s1_sample_r) * PROD_W'(base_scale_r);
  assign shifted = EXT_W'(product) >> stat.gain_used;
  assign current = stat.current_valid ? shifted[arcs_pkg::CURRENT_W-1:0] : '0;

  // Result register.
  logic                           out_valid_r;
  logic                           cur_valid_r;
  logic [arcs_pkg::CURRENT_W-1:0] current_r;
  logic [arcs_pkg::GAIN_W-1:0]    gain_used_r;
  logic [arcs_pkg::GAIN_W-1:0]    gain_now_r;
  logic                           holding_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      cur_valid_r <= stat.current_valid;
      current_r   <= current;
      gain_used_r <= stat.gain_used;
      gain_now_r  <= stat.gain_now;
      holding_r   <= stat.holding_off;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_current_valid  = cur_valid_r;
  assign out_current_q16    = current_r;
  assign out_gain_used      = gain_used_r;
  assign out_gain_index_now = gain_now_r;
  assign out_select_pin_a   = gain_now_r[0];
  assign out_select_pin_b   = gain_now_r[1];
  assign out_holding_off    = holding_r;

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
// Self-checking testbench for auto_ranging_current_sense_core: directed and random words
// are checked against a built-in model of the gain ranging and holdoff logic.
// Depends on arcs_pkg and auto_ranging_current_sense_core.

module tb_top;

  localparam int unsigned SAMPLE_W = 12;
  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam int unsigned LONG_HOLD = 80;

  typedef logic [SAMPLE_W-1:0]              sample_t;
  typedef logic [arcs_pkg::TICKS_W-1:0]     ticks_t;
  typedef logic [arcs_pkg::CFG_IDX_W-1:0]   cfg_idx_t;
  typedef logic [arcs_pkg::CFG_DATA_W-1:0]  cfg_data_t;
  typedef logic [arcs_pkg::CURRENT_W-1:0]   current_t;

  localparam sample_t SAMPLE_MAX = '1;
  localparam ticks_t TICKS_MAX = '1;
  localparam cfg_idx_t REG_SPARE_FIRST = 3'd4;

  // One result word as the block presents it.
  typedef struct packed {
    logic                           current_valid;
    logic [arcs_pkg::CURRENT_W-1:0] current_q16;
    logic [arcs_pkg::GAIN_W-1:0]    gain_used;
    logic [arcs_pkg::GAIN_W-1:0]    gain_index_now;
    logic                           select_pin_a;
    logic                           select_pin_b;
    logic                           holding_off;
  } sense_word_t;

  // Tracks gain and holdoff state and holds the result words still owed.
  class gain_tracker;
    logic [arcs_pkg::LIMIT_W-1:0] high_limit;
    logic [arcs_pkg::LIMIT_W-1:0] low_limit;
    logic [arcs_pkg::TICKS_W-1:0] holdoff_ticks;
    logic [arcs_pkg::SCALE_W-1:0] base_scale;
    logic [arcs_pkg::GAIN_W-1:0]  gain_idx;
    logic [arcs_pkg::TICKS_W-1:0] tick_count;
    bit                           holdoff_on;
    sense_word_t                  owed_words[$];
    int                           errors;

    function new();
      high_limit    = arcs_pkg::HIGH_LIMIT_RST;
      low_limit     = arcs_pkg::LOW_LIMIT_RST;
      holdoff_ticks = arcs_pkg::HOLDOFF_TICKS_RST;
      base_scale    = arcs_pkg::BASE_SCALE_RST;
      gain_idx      = arcs_pkg::GAIN_TOP;
      holdoff_on    = 1'b1;
      tick_count    = '0;
      errors        = 0;
    endfunction

    function void write_reg(cfg_idx_t idx, cfg_data_t data);
      case (idx)
        arcs_pkg::REG_HIGH_LIMIT:    high_limit = data[arcs_pkg::LIMIT_W-1:0];
        arcs_pkg::REG_LOW_LIMIT:     low_limit = data[arcs_pkg::LIMIT_W-1:0];
        arcs_pkg::REG_HOLDOFF_TICKS: holdoff_ticks = data[arcs_pkg::TICKS_W-1:0];
        arcs_pkg::REG_BASE_SCALE:    base_scale = data[arcs_pkg::SCALE_W-1:0];
        default: ;
      endcase
    endfunction

    // A gain step always restarts the holdoff from zero.
    function void change_range(logic [arcs_pkg::GAIN_W-1:0] g);
      gain_idx   = g;
      holdoff_on = 1'b1;
      tick_count = '0;
    endfunction

    // Notes an accepted input word and queues the result it must produce.
    function void note_word(logic func, sample_t sample);
      sense_word_t w;
      current_t product;
      w = '0;
      w.gain_used = gain_idx;
      if (func == arcs_pkg::FUNC_TICK) begin
        if (holdoff_on) begin
          if (tick_count != TICKS_MAX) tick_count = tick_count + 1'b1;
          if (tick_count >= holdoff_ticks) begin
            holdoff_on = 1'b0;
            tick_count = '0;
          end
        end
      end else if (!holdoff_on) begin
        product = current_t'(sample) * current_t'(base_scale);
        w.current_valid = 1'b1;
        w.current_q16 = product >> gain_idx;
        // The high limit test wins when the limits overlap.
        if (gain_idx > arcs_pkg::GAIN_BOTTOM && sample >= high_limit)
          change_range(gain_idx - 1'b1);
        else if (gain_idx < arcs_pkg::GAIN_TOP && sample <= low_limit)
          change_range(gain_idx + 1'b1);
      end
      w.gain_index_now = gain_idx;
      w.select_pin_a   = gain_idx[0];
      w.select_pin_b   = gain_idx[1];
      w.holding_off    = holdoff_on;
      owed_words.push_back(w);
    endfunction

    function void compare_field(string name, current_t want, current_t got);
      if (want !== got) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        errors++;
      end
    endfunction

    // Checks a delivered result word against the oldest one owed.
    function void check_word(sense_word_t got);
      sense_word_t want;
      if (owed_words.size() == 0) begin
        $error("result word delivered with none pending");
        errors++;
        return;
      end
      want = owed_words.pop_front();
      compare_field("current_valid", current_t'(want.current_valid),
                    current_t'(got.current_valid));
      compare_field("current_q16", want.current_q16, got.current_q16);
      compare_field("gain_used", current_t'(want.gain_used), current_t'(got.gain_used));
      compare_field("gain_index_now", current_t'(want.gain_index_now),
                    current_t'(got.gain_index_now));
      compare_field("select_pin_a", current_t'(want.select_pin_a),
                    current_t'(got.select_pin_a));
      compare_field("select_pin_b", current_t'(want.select_pin_b),
                    current_t'(got.select_pin_b));
      compare_field("holding_off", current_t'(want.holding_off),
                    current_t'(got.holding_off));
    endfunction

    function int pending();
      return owed_words.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic in_func = arcs_pkg::FUNC_SAMPLE;
  sample_t in_sample = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic out_current_valid;
  current_t out_current_q16;
  logic [arcs_pkg::GAIN_W-1:0] out_gain_used;
  logic [arcs_pkg::GAIN_W-1:0] out_gain_index_now;
  logic out_select_pin_a;
  logic out_select_pin_b;
  logic out_holding_off;
  logic cfg_we = 1'b0;
  cfg_idx_t cfg_index = '0;
  cfg_data_t cfg_wdata = '0;

  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned holds_asked = 0;
  int unsigned holds_served = 0;
  int unsigned hold_left = 0;
  int unsigned cycle_count = 0;

  gain_tracker tracker = new();

  auto_ranging_current_sense_core u_top (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_func            (in_func),
    .in_sample          (in_sample),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_current_valid  (out_current_valid),
    .out_current_q16    (out_current_q16),
    .out_gain_used      (out_gain_used),
    .out_gain_index_now (out_gain_index_now),
    .out_select_pin_a   (out_select_pin_a),
    .out_select_pin_b   (out_select_pin_b),
    .out_holding_off    (out_holding_off),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Run limit in case the handshake hangs.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Both channels are observed at the rising edge, before the block updates.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        tracker.check_word({out_current_valid, out_current_q16, out_gain_used,
                            out_gain_index_now, out_select_pin_a, out_select_pin_b,
                            out_holding_off});
      end
      if (in_valid && !in_stall) tracker.note_word(in_func, in_sample);
    end
  end

  // Result side: random stalls, plus long hold-offs on request.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (holds_served != holds_asked) begin
      holds_served <= holds_served + 1;
      hold_left <= LONG_HOLD;
      out_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Offers one word, with random idle cycles first; returns after a falling edge.
  task automatic send_word(input logic func, input sample_t sample);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      in_func <= ($urandom_range(1) != 0);
      in_sample <= sample_t'($urandom);
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_func <= func;
    in_sample <= sample;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_ticks(input int unsigned n);
    repeat (n) send_word(arcs_pkg::FUNC_TICK, sample_t'($urandom));
  endtask

  // Stops offering words until every owed result has come back.
  task automatic drain();
    in_valid <= 1'b0;
    do @(negedge clk); while (tracker.pending() != 0);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input cfg_data_t data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    tracker.write_reg(idx, data);
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_idling(input int unsigned send_pct, input int unsigned recv_pct);
    send_idle_pct = send_pct;
    recv_stall_pct = recv_pct;
  endtask

  // Random limits, a short holdoff and scale, with junk in the unused upper data bits.
  task automatic random_config();
    cfg_data_t junk;
    junk = cfg_data_t'($urandom);
    write_reg(arcs_pkg::REG_HIGH_LIMIT, junk);
    junk = cfg_data_t'($urandom);
    write_reg(arcs_pkg::REG_LOW_LIMIT, junk);
    junk = cfg_data_t'($urandom);
    junk[arcs_pkg::TICKS_W-1:0] = ticks_t'($urandom_range(5));
    write_reg(arcs_pkg::REG_HOLDOFF_TICKS, junk);
    write_reg(arcs_pkg::REG_BASE_SCALE, cfg_data_t'($urandom));
  endtask

  // Samples cluster around both limits, with some extremes and uniform values.
  function automatic sample_t pick_sample();
    int v;
    case ($urandom_range(9))
      0, 1, 2: v = int'(tracker.high_limit) + int'($urandom_range(4)) - 2;
      3, 4, 5: v = int'(tracker.low_limit) + int'($urandom_range(4)) - 2;
      6:       v = $urandom_range(1) ? int'(SAMPLE_MAX) : 0;
      default: v = int'($urandom_range(SAMPLE_MAX));
    endcase
    if (v < 0) v = 0;
    if (v > int'(SAMPLE_MAX)) v = int'(SAMPLE_MAX);
    return v[SAMPLE_W-1:0];
  endfunction

  // Mostly ticks during a holdoff and samples outside it.
  task automatic run_words(input int unsigned n);
    logic func;
    repeat (n) begin
      if (tracker.holdoff_on)
        func = ($urandom_range(99) < 80) ? arcs_pkg::FUNC_TICK : arcs_pkg::FUNC_SAMPLE;
      else
        func = ($urandom_range(99) < 8) ? arcs_pkg::FUNC_TICK : arcs_pkg::FUNC_SAMPLE;
      send_word(func, pick_sample());
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset settings: samples are ignored while the default holdoff runs.
    send_word(arcs_pkg::FUNC_SAMPLE, SAMPLE_MAX);
    send_word(arcs_pkg::FUNC_SAMPLE, '0);
    send_ticks(3);
    drain();
    write_reg(arcs_pkg::REG_HOLDOFF_TICKS, cfg_data_t'(4));
    send_ticks(1);
    send_word(arcs_pkg::FUNC_SAMPLE, SAMPLE_MAX);

    // Zero holdoff; writes to unused register indexes must change nothing.
    drain();
    write_reg(arcs_pkg::REG_HOLDOFF_TICKS, '0);
    for (int k = 0; k < 4; k++) write_reg(REG_SPARE_FIRST + cfg_idx_t'(k), '1);
    send_ticks(1);
    send_word(arcs_pkg::FUNC_SAMPLE, '0);
    send_ticks(1);
    send_word(arcs_pkg::FUNC_SAMPLE, '0);
    send_word(arcs_pkg::FUNC_SAMPLE, arcs_pkg::HIGH_LIMIT_RST);
    send_ticks(1);
    send_word(arcs_pkg::FUNC_SAMPLE, arcs_pkg::HIGH_LIMIT_RST);
    send_ticks(1);
    send_word(arcs_pkg::FUNC_SAMPLE, SAMPLE_MAX);
    send_ticks(1);
    send_word(arcs_pkg::FUNC_SAMPLE, SAMPLE_MAX);

    // Overlapping limits and the widest product.
    drain();
    write_reg(arcs_pkg::REG_HIGH_LIMIT, 24'd100);
    write_reg(arcs_pkg::REG_LOW_LIMIT, 24'd200);
    write_reg(arcs_pkg::REG_BASE_SCALE, '1);
    send_word(arcs_pkg::FUNC_SAMPLE, 12'd150);
    send_ticks(1);
    send_word(arcs_pkg::FUNC_SAMPLE, 12'd150);
    send_ticks(1);
    send_word(arcs_pkg::FUNC_SAMPLE, SAMPLE_MAX);

    // Zero scale, extreme limits and the longest holdoff, later cut short.
    drain();
    write_reg(arcs_pkg::REG_BASE_SCALE, '0);
    write_reg(arcs_pkg::REG_HIGH_LIMIT, '0);
    write_reg(arcs_pkg::REG_LOW_LIMIT, '1);
    write_reg(arcs_pkg::REG_HOLDOFF_TICKS, cfg_data_t'(TICKS_MAX));
    send_word(arcs_pkg::FUNC_SAMPLE, 12'd2048);
    send_word(arcs_pkg::FUNC_SAMPLE, 12'd2048);
    send_ticks(3);
    drain();
    write_reg(arcs_pkg::REG_HOLDOFF_TICKS, 24'd1);
    send_ticks(1);
    send_word(arcs_pkg::FUNC_SAMPLE, SAMPLE_MAX);

    // Random phases under different idling.
    drain();
    write_reg(arcs_pkg::REG_HOLDOFF_TICKS, 24'd1);
    write_reg(arcs_pkg::REG_BASE_SCALE, cfg_data_t'($urandom));
    set_idling(58, 0);
    run_words(240);

    drain();
    write_reg(arcs_pkg::REG_HIGH_LIMIT, '1);
    write_reg(arcs_pkg::REG_LOW_LIMIT, '0);
    write_reg(arcs_pkg::REG_HOLDOFF_TICKS, 24'd2);
    set_idling(0, 58);
    run_words(240);

    drain();
    random_config();
    set_idling(19, 19);
    run_words(240);

    // Long result stall while words keep coming, then a full pause.
    drain();
    random_config();
    set_idling(0, 0);
    run_words(120);
    holds_asked = holds_asked + 1;
    run_words(60);
    drain();
    run_words(60);

    drain();
    random_config();
    set_idling(58, 0);
    run_words(240);

    drain();
    random_config();
    set_idling(0, 58);
    run_words(120);
    set_idling(19, 19);
    run_words(120);

    drain();
    repeat (8) @(posedge clk);
    if (tracker.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
